// ===== hw/rtl/dttd_pkg.sv =====
// Shared types, constants and a helper function of the decimal text to double converter.
package dttd_pkg;

    localparam logic [63:0] DBL_ZERO = 64'h0000_0000_0000_0000;
    localparam logic [63:0] DBL_ONE = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DBL_TEN = 64'h4024_0000_0000_0000;
    localparam logic [63:0] DBL_TENTH = 64'h3FB9_9999_9999_999A;
    localparam logic [63:0] DBL_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_DOT = 8'd46;
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_NINE = 8'd57;
    localparam logic [7:0] CH_UPPER_E = 8'd69;
    localparam logic [7:0] CH_LOWER_E = 8'd101;

    typedef enum logic [2:0] {
        PH_BLANK,
        PH_INT,
        PH_FRAC,
        PH_EXPSIGN,
        PH_EXPDIG,
        PH_STOP
    } phase_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_INT,
        ACT_FRAC,
        ACT_EXP
    } act_t;

    typedef struct packed {
        phase_t     ph_next;
        act_t       act;
        logic       set_mneg;
        logic       set_eneg;
        logic [3:0] digit;
    } scan_t;

    typedef enum logic [1:0] {
        FOP_MUL,
        FOP_ADD,
        FOP_DIV
    } fop_t;

    typedef struct packed {
        logic        start;
        fop_t        op;
        logic [63:0] a;
        logic [63:0] b;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } fpu_rsp_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_MUL,
        F_ADD,
        F_PRE,
        F_DIV,
        F_DIVEND,
        F_NORM,
        F_RSH,
        F_ROUND,
        F_DONE
    } fpu_state_t;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_DECODE,
        SQ_INT_MUL,
        SQ_INT_ADD,
        SQ_FRAC_SCALE,
        SQ_FRAC_MUL,
        SQ_FRAC_ADD,
        SQ_POW_CHECK,
        SQ_POW_MUL,
        SQ_POW_SQR,
        SQ_APPLY,
        SQ_OUT
    } seq_state_t;

    // Binary64 pattern of a decimal digit.
    function automatic logic [63:0] digit_to_double(input logic [3:0] d);
        logic [63:0] v;
        case (d)
            4'd0: v = 64'h0000_0000_0000_0000;
            4'd1: v = 64'h3FF0_0000_0000_0000;
            4'd2: v = 64'h4000_0000_0000_0000;
            4'd3: v = 64'h4008_0000_0000_0000;
            4'd4: v = 64'h4010_0000_0000_0000;
            4'd5: v = 64'h4014_0000_0000_0000;
            4'd6: v = 64'h4018_0000_0000_0000;
            4'd7: v = 64'h401C_0000_0000_0000;
            4'd8: v = 64'h4020_0000_0000_0000;
            4'd9: v = 64'h4022_0000_0000_0000;
            default: v = 64'h0000_0000_0000_0000;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/dttd_scan.sv =====
// Character classifier: decides the next parse phase and the action for one byte.
module dttd_scan
(
    input  dttd_pkg::phase_t phase,
    input  logic [7:0]       ch,
    output dttd_pkg::scan_t  scan
);

    logic is_dig;
    logic is_e;
    logic [7:0] dval;

    assign is_dig = (ch >= dttd_pkg::CH_ZERO) && (ch <= dttd_pkg::CH_NINE);
    assign is_e = (ch == dttd_pkg::CH_LOWER_E) || (ch == dttd_pkg::CH_UPPER_E);
    assign dval = ch - dttd_pkg::CH_ZERO;

    always_comb
    begin
        scan.ph_next = phase;
        scan.act = dttd_pkg::ACT_NONE;
        scan.set_mneg = 1'b0;
        scan.set_eneg = 1'b0;
        scan.digit = dval[3:0];
        case (phase)
            dttd_pkg::PH_BLANK, dttd_pkg::PH_INT:
            begin
                if ((phase == dttd_pkg::PH_BLANK) &&
                    ((ch == dttd_pkg::CH_SPACE) || (ch == dttd_pkg::CH_TAB)))
                begin
                    scan.ph_next = dttd_pkg::PH_BLANK;
                end
                else if ((phase == dttd_pkg::PH_BLANK) && (ch == dttd_pkg::CH_MINUS))
                begin
                    scan.set_mneg = 1'b1;
                    scan.ph_next = dttd_pkg::PH_INT;
                end
                else if ((phase == dttd_pkg::PH_BLANK) && (ch == dttd_pkg::CH_PLUS))
                begin
                    scan.ph_next = dttd_pkg::PH_INT;
                end
                else if (is_dig)
                begin
                    scan.act = dttd_pkg::ACT_INT;
                    scan.ph_next = dttd_pkg::PH_INT;
                end
                else if (ch == dttd_pkg::CH_DOT)
                begin
                    scan.ph_next = dttd_pkg::PH_FRAC;
                end
                else if (is_e)
                begin
                    scan.ph_next = dttd_pkg::PH_EXPSIGN;
                end
                else
                begin
                    scan.ph_next = dttd_pkg::PH_STOP;
                end
            end
            dttd_pkg::PH_FRAC:
            begin
                if (is_dig)
                begin
                    scan.act = dttd_pkg::ACT_FRAC;
                end
                else if (is_e)
                begin
                    scan.ph_next = dttd_pkg::PH_EXPSIGN;
                end
                else
                begin
                    scan.ph_next = dttd_pkg::PH_STOP;
                end
            end
            dttd_pkg::PH_EXPSIGN:
            begin
                if (ch == dttd_pkg::CH_MINUS)
                begin
                    scan.set_eneg = 1'b1;
                    scan.ph_next = dttd_pkg::PH_EXPDIG;
                end
                else if (ch == dttd_pkg::CH_PLUS)
                begin
                    scan.ph_next = dttd_pkg::PH_EXPDIG;
                end
                else if (is_dig)
                begin
                    scan.act = dttd_pkg::ACT_EXP;
                    scan.ph_next = dttd_pkg::PH_EXPDIG;
                end
                else
                begin
                    scan.ph_next = dttd_pkg::PH_STOP;
                end
            end
            dttd_pkg::PH_EXPDIG:
            begin
                if (is_dig)
                begin
                    scan.act = dttd_pkg::ACT_EXP;
                end
                else
                begin
                    scan.ph_next = dttd_pkg::PH_STOP;
                end
            end
            default:
            begin
                scan.ph_next = phase;
            end
        endcase
    end

endmodule

// ===== hw/rtl/dttd_fpu.sv =====
// Shared iterative binary64 unit: multiply, add and divide with round to nearest even.
module dttd_fpu
(
    input  logic               clk,
    input  logic               rst_n,
    input  dttd_pkg::fpu_req_t req,
    output dttd_pkg::fpu_rsp_t rsp
);

    dttd_pkg::fpu_state_t state_reg;
    dttd_pkg::fpu_state_t state_next;

    logic [127:0]       opa_reg;
    logic [127:0]       opb_reg;
    logic [127:0]       sig_reg;
    logic [54:0]        rem_reg;
    logic signed [15:0] exp_reg;
    logic               sign_reg;
    logic               sgna_reg;
    logic               sgnb_reg;
    logic [6:0]         cnt_reg;
    logic [63:0]        res_reg;

    // Operand unpack.
    logic               sa;
    logic               sb;
    logic [10:0]        ea;
    logic [10:0]        eb;
    logic [51:0]        fa;
    logic [51:0]        fb;
    logic [52:0]        ma;
    logic [52:0]        mb;
    logic signed [15:0] xa;
    logic signed [15:0] xb;
    logic               a_nan;
    logic               b_nan;
    logic               a_inf;
    logic               b_inf;
    logic               a_zero;
    logic               b_zero;
    logic               spec_hit;
    logic [63:0]        spec_val;

    assign sa = req.a[63];
    assign sb = req.b[63];
    assign ea = req.a[62:52];
    assign eb = req.b[62:52];
    assign fa = req.a[51:0];
    assign fb = req.b[51:0];
    assign ma = {(ea != 11'd0), fa};
    assign mb = {(eb != 11'd0), fb};
    assign xa = $signed({5'd0, ((ea == 11'd0) ? 11'd1 : ea)}) - 16'sd1075;
    assign xb = $signed({5'd0, ((eb == 11'd0) ? 11'd1 : eb)}) - 16'sd1075;
    assign a_nan = (ea == 11'h7FF) && (fa != 52'd0);
    assign b_nan = (eb == 11'h7FF) && (fb != 52'd0);
    assign a_inf = (ea == 11'h7FF) && (fa == 52'd0);
    assign b_inf = (eb == 11'h7FF) && (fb == 52'd0);
    assign a_zero = (ea == 11'd0) && (fa == 52'd0);
    assign b_zero = (eb == 11'd0) && (fb == 52'd0);

    always_comb
    begin
        spec_hit = 1'b1;
        spec_val = dttd_pkg::DBL_DEFAULT_NAN;
        if (a_nan)
        begin
            spec_val = req.a | (64'd1 << 51);
        end
        else if (b_nan)
        begin
            spec_val = req.b | (64'd1 << 51);
        end
        else
        begin
            case (req.op)
                dttd_pkg::FOP_MUL:
                begin
                    if ((a_inf && b_zero) || (a_zero && b_inf))
                        spec_val = dttd_pkg::DBL_DEFAULT_NAN;
                    else if (a_inf || b_inf)
                        spec_val = {sa ^ sb, 11'h7FF, 52'd0};
                    else if (a_zero || b_zero)
                        spec_val = {sa ^ sb, 63'd0};
                    else
                        spec_hit = 1'b0;
                end
                dttd_pkg::FOP_DIV:
                begin
                    if ((a_inf && b_inf) || (a_zero && b_zero))
                        spec_val = dttd_pkg::DBL_DEFAULT_NAN;
                    else if (a_inf || b_zero)
                        spec_val = {sa ^ sb, 11'h7FF, 52'd0};
                    else if (a_zero || b_inf)
                        spec_val = {sa ^ sb, 63'd0};
                    else
                        spec_hit = 1'b0;
                end
                dttd_pkg::FOP_ADD:
                begin
                    if (a_inf && b_inf && (sa != sb))
                        spec_val = dttd_pkg::DBL_DEFAULT_NAN;
                    else if (a_inf)
                        spec_val = req.a;
                    else if (b_inf)
                        spec_val = req.b;
                    else if (a_zero && b_zero)
                        spec_val = {sa & sb, 63'd0};
                    else if (a_zero)
                        spec_val = req.b;
                    else if (b_zero)
                        spec_val = req.a;
                    else
                        spec_hit = 1'b0;
                end
                default:
                begin
                    spec_val = dttd_pkg::DBL_DEFAULT_NAN;
                end
            endcase
        end
    end

    // Addend alignment: the operand with the smaller exponent is shifted right with a sticky bit at bit 0.
    logic               a_ge;
    logic [52:0]        big_m;
    logic [52:0]        small_m;
    logic signed [15:0] big_x;
    logic signed [15:0] shift_amt;
    logic [127:0]       big_frame;
    logic [127:0]       small_frame;
    logic [127:0]       small_sh;
    logic               small_lost;
    logic [127:0]       small_al;

    assign a_ge = (xa >= xb);
    assign big_m = a_ge ? ma : mb;
    assign small_m = a_ge ? mb : ma;
    assign big_x = a_ge ? xa : xb;
    assign shift_amt = a_ge ? (xa - xb) : (xb - xa);
    assign big_frame = {11'd0, big_m, 64'd0};
    assign small_frame = {11'd0, small_m, 64'd0};
    assign small_sh = small_frame >> shift_amt[6:0];
    assign small_lost = |(small_frame & ((128'd1 << shift_amt[6:0]) - 128'd1));
    assign small_al = (shift_amt > 16'sd119) ? 128'd1 : (small_sh | {127'd0, small_lost});

    // Signed-magnitude add of the aligned frames.
    logic         add_ge;
    logic [127:0] add_res;
    logic         add_sign;

    assign add_ge = (opa_reg >= opb_reg);

    always_comb
    begin
        if (sgna_reg == sgnb_reg)
        begin
            add_res = opa_reg + opb_reg;
            add_sign = sgna_reg;
        end
        else if (add_ge)
        begin
            add_res = opa_reg - opb_reg;
            add_sign = sgna_reg;
        end
        else
        begin
            add_res = opb_reg - opa_reg;
            add_sign = sgnb_reg;
        end
    end

    // One quotient bit per cycle.
    logic        div_ge;
    logic [54:0] div_rem;

    assign div_ge = (rem_reg >= {2'd0, opb_reg[52:0]});
    assign div_rem = div_ge ? (rem_reg - {2'd0, opb_reg[52:0]}) : rem_reg;

    // Rounding and packing.
    logic signed [15:0] be;
    logic [52:0]        rnd_m;
    logic               rnd_g;
    logic               rnd_s;
    logic               rnd_inc;
    logic [53:0]        rnd_sum;
    logic [52:0]        rnd_m2;
    logic signed [15:0] rnd_be2;
    logic [63:0]        rnd_val;

    assign be = exp_reg + 16'sd1150;
    assign rnd_m = sig_reg[127:75];
    assign rnd_g = sig_reg[74];
    assign rnd_s = |sig_reg[73:0];
    assign rnd_inc = rnd_g && (rnd_s || rnd_m[0]);
    assign rnd_sum = {1'b0, rnd_m} + {53'd0, rnd_inc};
    assign rnd_m2 = rnd_sum[53] ? rnd_sum[53:1] : rnd_sum[52:0];
    assign rnd_be2 = rnd_sum[53] ? (be + 16'sd1) : be;
    assign rnd_val = (rnd_be2 > 16'sd2046) ? {sign_reg, 11'h7FF, 52'd0} :
                     {sign_reg, (rnd_m2[52] ? rnd_be2[10:0] : 11'd0), rnd_m2[51:0]};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dttd_pkg::F_IDLE:
            begin
                if (req.start)
                begin
                    if (spec_hit)
                        state_next = dttd_pkg::F_DONE;
                    else if (req.op == dttd_pkg::FOP_MUL)
                        state_next = dttd_pkg::F_MUL;
                    else if (req.op == dttd_pkg::FOP_ADD)
                        state_next = dttd_pkg::F_ADD;
                    else
                        state_next = dttd_pkg::F_PRE;
                end
            end
            dttd_pkg::F_MUL:
            begin
                if (cnt_reg == 7'd1)
                    state_next = dttd_pkg::F_NORM;
            end
            dttd_pkg::F_ADD:
            begin
                state_next = dttd_pkg::F_NORM;
            end
            dttd_pkg::F_PRE:
            begin
                if (opa_reg[52] && opb_reg[52])
                    state_next = dttd_pkg::F_DIV;
            end
            dttd_pkg::F_DIV:
            begin
                if (cnt_reg == 7'd1)
                    state_next = dttd_pkg::F_DIVEND;
            end
            dttd_pkg::F_DIVEND:
            begin
                state_next = dttd_pkg::F_NORM;
            end
            dttd_pkg::F_NORM:
            begin
                if (sig_reg == 128'd0)
                    state_next = dttd_pkg::F_DONE;
                else if (sig_reg[127])
                    state_next = dttd_pkg::F_RSH;
            end
            dttd_pkg::F_RSH:
            begin
                if (be >= 16'sd1)
                    state_next = dttd_pkg::F_ROUND;
            end
            dttd_pkg::F_ROUND:
            begin
                state_next = dttd_pkg::F_DONE;
            end
            dttd_pkg::F_DONE:
            begin
                state_next = dttd_pkg::F_IDLE;
            end
            default:
            begin
                state_next = dttd_pkg::F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp.done = (state_reg == dttd_pkg::F_DONE);
        rsp.result = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dttd_pkg::F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            dttd_pkg::F_IDLE:
            begin
                if (req.start)
                begin
                    res_reg <= spec_val;
                    case (req.op)
                        dttd_pkg::FOP_MUL:
                        begin
                            opa_reg <= {75'd0, ma};
                            opb_reg <= {75'd0, mb};
                            sig_reg <= 128'd0;
                            exp_reg <= xa + xb;
                            sign_reg <= sa ^ sb;
                            cnt_reg <= 7'd53;
                        end
                        dttd_pkg::FOP_ADD:
                        begin
                            opa_reg <= big_frame;
                            opb_reg <= small_al;
                            exp_reg <= big_x - 16'sd64;
                            sgna_reg <= a_ge ? sa : sb;
                            sgnb_reg <= a_ge ? sb : sa;
                        end
                        default:
                        begin
                            opa_reg <= {75'd0, ma};
                            opb_reg <= {75'd0, mb};
                            sig_reg <= 128'd0;
                            exp_reg <= xa - xb - 16'sd61;
                            sign_reg <= sa ^ sb;
                            cnt_reg <= 7'd61;
                        end
                    endcase
                end
            end
            dttd_pkg::F_MUL:
            begin
                if (opb_reg[0])
                    sig_reg <= sig_reg + opa_reg;
                opa_reg <= {opa_reg[126:0], 1'b0};
                opb_reg <= {1'b0, opb_reg[127:1]};
                cnt_reg <= cnt_reg - 7'd1;
            end
            dttd_pkg::F_ADD:
            begin
                sig_reg <= add_res;
                sign_reg <= add_sign;
            end
            dttd_pkg::F_PRE:
            begin
                // Both divide operands are brought to a leading one at bit 52 first.
                if (!opa_reg[52])
                    opa_reg <= {opa_reg[126:0], 1'b0};
                if (!opb_reg[52])
                    opb_reg <= {opb_reg[126:0], 1'b0};
                exp_reg <= exp_reg - {15'd0, !opa_reg[52]} + {15'd0, !opb_reg[52]};
                rem_reg <= {2'd0, opa_reg[52:0]};
            end
            dttd_pkg::F_DIV:
            begin
                rem_reg <= {div_rem[53:0], 1'b0};
                sig_reg <= {sig_reg[126:0], div_ge};
                cnt_reg <= cnt_reg - 7'd1;
            end
            dttd_pkg::F_DIVEND:
            begin
                sig_reg <= {sig_reg[126:0], (rem_reg != 55'd0)};
            end
            dttd_pkg::F_NORM:
            begin
                if (sig_reg == 128'd0)
                    res_reg <= dttd_pkg::DBL_ZERO;
                else if (!sig_reg[127])
                begin
                    if (sig_reg[127:120] == 8'd0)
                    begin
                        sig_reg <= {sig_reg[119:0], 8'd0};
                        exp_reg <= exp_reg - 16'sd8;
                    end
                    else
                    begin
                        sig_reg <= {sig_reg[126:0], 1'b0};
                        exp_reg <= exp_reg - 16'sd1;
                    end
                end
            end
            dttd_pkg::F_RSH:
            begin
                // Below the normal range the significand slides right into the sticky bit.
                if (be < 16'sd1)
                begin
                    if (be < -16'sd130)
                    begin
                        sig_reg <= {127'd0, (sig_reg != 128'd0)};
                        exp_reg <= -16'sd1149;
                    end
                    else
                    begin
                        sig_reg <= {1'b0, sig_reg[127:2], sig_reg[1] | sig_reg[0]};
                        exp_reg <= exp_reg + 16'sd1;
                    end
                end
            end
            dttd_pkg::F_ROUND:
            begin
                res_reg <= rnd_val;
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

endmodule

// ===== hw/rtl/decimal_text_to_double.sv =====
// Top level: character-serial decimal number parser with a shared binary64 unit.
// One byte at a time: a blank, sign, dot or exponent byte is only decoded, a digit byte also runs
// the shared unit (an integer digit a multiply and an add, a fraction digit two multiplies and an add).
// The last byte adds up to 2*EXP_BITS multiplies and then a final multiply or divide, and the
// result beat is loaded in SQ_OUT, which waits while an earlier result beat is stalled.
// Reset (rst_n low, asynchronous) returns the parser to the leading blank phase, no beat pending.
module decimal_text_to_double
#(
    parameter int EXP_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [63:0] value_bits
);

    localparam logic [EXP_BITS-1:0] EXP_MAX = {EXP_BITS{1'b1}};

    dttd_pkg::seq_state_t state_reg;
    dttd_pkg::seq_state_t state_next;
    dttd_pkg::phase_t     phase_reg;
    dttd_pkg::scan_t      scan;
    dttd_pkg::fpu_req_t   fpu_req;
    dttd_pkg::fpu_rsp_t   fpu_rsp;

    logic [7:0]          ch_reg;
    logic                last_reg;
    logic [3:0]          digit_reg;
    logic [63:0]         acc_reg;
    logic [63:0]         fs_reg;
    logic [63:0]         tmp_reg;
    logic [63:0]         pow_reg;
    logic [63:0]         base_reg;
    logic [63:0]         r_reg;
    logic                mneg_reg;
    logic                eneg_reg;
    logic [EXP_BITS-1:0] expc_reg;
    logic [EXP_BITS-1:0] e_reg;
    logic                issued_reg;
    logic                m_tvalid_reg;
    logic [63:0]         m_tdata_reg;

    logic [EXP_BITS+3:0] exp_mac;
    logic [EXP_BITS-1:0] expc_upd;
    logic                op_state;
    logic                out_free;
    logic                r_nan;

    dttd_scan u_scan
    (
        .phase (phase_reg),
        .ch    (ch_reg),
        .scan  (scan)
    );

    dttd_fpu u_fpu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fpu_req),
        .rsp   (fpu_rsp)
    );

    assign exp_mac = {4'd0, expc_reg} * (EXP_BITS + 4)'(10) + {{EXP_BITS{1'b0}}, scan.digit};
    assign expc_upd = (scan.act != dttd_pkg::ACT_EXP) ? expc_reg :
                      ((exp_mac > {4'd0, EXP_MAX}) ? EXP_MAX : exp_mac[EXP_BITS-1:0]);
    assign out_free = !m_tvalid_reg || m_tready;
    assign r_nan = (r_reg[62:52] == 11'h7FF) && (r_reg[51:0] != 52'd0);

    always_comb
    begin
        case (state_reg)
            dttd_pkg::SQ_INT_MUL, dttd_pkg::SQ_INT_ADD, dttd_pkg::SQ_FRAC_SCALE,
            dttd_pkg::SQ_FRAC_MUL, dttd_pkg::SQ_FRAC_ADD, dttd_pkg::SQ_POW_MUL,
            dttd_pkg::SQ_POW_SQR, dttd_pkg::SQ_APPLY:
                op_state = 1'b1;
            default:
                op_state = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dttd_pkg::SQ_IDLE:
            begin
                if (s_tvalid)
                    state_next = dttd_pkg::SQ_DECODE;
            end
            dttd_pkg::SQ_DECODE:
            begin
                if (scan.act == dttd_pkg::ACT_INT)
                    state_next = dttd_pkg::SQ_INT_MUL;
                else if (scan.act == dttd_pkg::ACT_FRAC)
                    state_next = dttd_pkg::SQ_FRAC_SCALE;
                else if (last_reg)
                    state_next = dttd_pkg::SQ_POW_CHECK;
                else
                    state_next = dttd_pkg::SQ_IDLE;
            end
            dttd_pkg::SQ_INT_MUL:
            begin
                if (fpu_rsp.done)
                    state_next = dttd_pkg::SQ_INT_ADD;
            end
            dttd_pkg::SQ_FRAC_SCALE:
            begin
                if (fpu_rsp.done)
                    state_next = dttd_pkg::SQ_FRAC_MUL;
            end
            dttd_pkg::SQ_FRAC_MUL:
            begin
                if (fpu_rsp.done)
                    state_next = dttd_pkg::SQ_FRAC_ADD;
            end
            dttd_pkg::SQ_INT_ADD, dttd_pkg::SQ_FRAC_ADD:
            begin
                if (fpu_rsp.done)
                    state_next = last_reg ? dttd_pkg::SQ_POW_CHECK : dttd_pkg::SQ_IDLE;
            end
            dttd_pkg::SQ_POW_CHECK:
            begin
                if (e_reg == '0)
                    state_next = dttd_pkg::SQ_APPLY;
                else if (e_reg[0])
                    state_next = dttd_pkg::SQ_POW_MUL;
                else
                    state_next = dttd_pkg::SQ_POW_SQR;
            end
            dttd_pkg::SQ_POW_MUL:
            begin
                if (fpu_rsp.done)
                    state_next = dttd_pkg::SQ_POW_SQR;
            end
            dttd_pkg::SQ_POW_SQR:
            begin
                if (fpu_rsp.done)
                    state_next = dttd_pkg::SQ_POW_CHECK;
            end
            dttd_pkg::SQ_APPLY:
            begin
                if (fpu_rsp.done)
                    state_next = dttd_pkg::SQ_OUT;
            end
            dttd_pkg::SQ_OUT:
            begin
                if (out_free)
                    state_next = dttd_pkg::SQ_IDLE;
            end
            default:
            begin
                state_next = dttd_pkg::SQ_IDLE;
            end
        endcase
    end

    // Outputs and operand selection for the shared unit.
    always_comb
    begin
        s_tready = (state_reg == dttd_pkg::SQ_IDLE);
        m_tvalid = m_tvalid_reg;
        m_tdata = m_tdata_reg;
        fpu_req.start = op_state && !issued_reg;
        fpu_req.op = dttd_pkg::FOP_MUL;
        fpu_req.a = acc_reg;
        fpu_req.b = dttd_pkg::DBL_TEN;
        case (state_reg)
            dttd_pkg::SQ_INT_ADD:
            begin
                fpu_req.op = dttd_pkg::FOP_ADD;
                fpu_req.b = dttd_pkg::digit_to_double(digit_reg);
            end
            dttd_pkg::SQ_FRAC_SCALE:
            begin
                fpu_req.a = fs_reg;
                fpu_req.b = dttd_pkg::DBL_TENTH;
            end
            dttd_pkg::SQ_FRAC_MUL:
            begin
                fpu_req.a = dttd_pkg::digit_to_double(digit_reg);
                fpu_req.b = fs_reg;
            end
            dttd_pkg::SQ_FRAC_ADD:
            begin
                fpu_req.op = dttd_pkg::FOP_ADD;
                fpu_req.b = tmp_reg;
            end
            dttd_pkg::SQ_POW_MUL:
            begin
                fpu_req.a = pow_reg;
                fpu_req.b = base_reg;
            end
            dttd_pkg::SQ_POW_SQR:
            begin
                fpu_req.a = base_reg;
                fpu_req.b = base_reg;
            end
            dttd_pkg::SQ_APPLY:
            begin
                fpu_req.op = eneg_reg ? dttd_pkg::FOP_DIV : dttd_pkg::FOP_MUL;
                fpu_req.b = pow_reg;
            end
            default:
            begin
                fpu_req.b = dttd_pkg::DBL_TEN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dttd_pkg::SQ_IDLE;
            issued_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            phase_reg <= dttd_pkg::PH_BLANK;
            acc_reg <= dttd_pkg::DBL_ZERO;
            fs_reg <= dttd_pkg::DBL_ONE;
            mneg_reg <= 1'b0;
            eneg_reg <= 1'b0;
            expc_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (fpu_rsp.done)
                issued_reg <= 1'b0;
            else if (fpu_req.start)
                issued_reg <= 1'b1;

            if ((state_reg == dttd_pkg::SQ_OUT) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                dttd_pkg::SQ_DECODE:
                begin
                    phase_reg <= scan.ph_next;
                    if (scan.set_mneg)
                        mneg_reg <= 1'b1;
                    if (scan.set_eneg)
                        eneg_reg <= 1'b1;
                    expc_reg <= expc_upd;
                end
                dttd_pkg::SQ_INT_MUL, dttd_pkg::SQ_INT_ADD, dttd_pkg::SQ_FRAC_ADD:
                begin
                    if (fpu_rsp.done)
                        acc_reg <= fpu_rsp.result;
                end
                dttd_pkg::SQ_FRAC_SCALE:
                begin
                    if (fpu_rsp.done)
                        fs_reg <= fpu_rsp.result;
                end
                dttd_pkg::SQ_OUT:
                begin
                    // The token is finished: back to the leading blank phase.
                    if (out_free)
                    begin
                        phase_reg <= dttd_pkg::PH_BLANK;
                        acc_reg <= dttd_pkg::DBL_ZERO;
                        fs_reg <= dttd_pkg::DBL_ONE;
                        mneg_reg <= 1'b0;
                        eneg_reg <= 1'b0;
                        expc_reg <= '0;
                    end
                end
                default:
                begin
                    phase_reg <= phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ch_reg <= s_tdata;
            last_reg <= s_tlast;
        end
        if (state_reg == dttd_pkg::SQ_DECODE)
        begin
            digit_reg <= scan.digit;
            e_reg <= expc_upd;
            pow_reg <= dttd_pkg::DBL_ONE;
            base_reg <= dttd_pkg::DBL_TEN;
        end
        if (fpu_rsp.done)
        begin
            case (state_reg)
                dttd_pkg::SQ_FRAC_MUL:
                    tmp_reg <= fpu_rsp.result;
                dttd_pkg::SQ_POW_MUL:
                    pow_reg <= fpu_rsp.result;
                dttd_pkg::SQ_POW_SQR:
                begin
                    base_reg <= fpu_rsp.result;
                    e_reg <= {1'b0, e_reg[EXP_BITS-1:1]};
                end
                dttd_pkg::SQ_APPLY:
                    r_reg <= fpu_rsp.result;
                default:
                    tmp_reg <= tmp_reg;
            endcase
        end
        // The sign is exact; a NaN passes unchanged.
        if ((state_reg == dttd_pkg::SQ_OUT) && out_free)
            m_tdata_reg <= r_nan ? r_reg : {r_reg[63] ^ mneg_reg, r_reg[62:0]};
    end

endmodule

// ===== hw/rtl/dttd_check.sv =====
// Port-level assertions for the decimal text to double converter, bound to the top level.
module dttd_check
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // Every accepted byte is decoded before the next one is taken.
    a_decode_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted in the cycle after a beat");

    // The final byte always starts the exponent pass, so s_tready stays low while it is decoded and after.
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready ##1 !s_tready)
        else $error("input accepted too early after the final byte");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result beat changed or dropped");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("result beat withdrawn without a handshake");

endmodule

bind decimal_text_to_double dttd_check u_dttd_check (.*);
